[sv/quadratic_root_solver_unit_defines.svh]
// Assertion macros for the quadratic root solver checker
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// implication checked in the same cycle
`define QRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the next cycle
`define QRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/qrs_pkg.sv]
// Types, constants and the per-stage step function of the quadratic root solver
package qrs_pkg;

    localparam int COEF_W     = 16;
    localparam int DISC_W     = 2 * COEF_W + 2;
    localparam int ROOT_W     = 32;
    localparam int SQ_PAIRS   = COEF_W + 1;
    localparam int SQ_FIRST   = 3;
    localparam int SQ_STEPS   = SQ_PAIRS + 16;
    localparam int PREP_STAGE = SQ_FIRST + SQ_STEPS;
    localparam int DIV_FIRST  = PREP_STAGE + 1;
    localparam int DIV_STEPS  = 35;
    localparam int FIN_STAGE  = DIV_FIRST + DIV_STEPS;
    localparam int DEPTH      = FIN_STAGE + 1;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 104;

    typedef enum logic [1:0] {
        ST_TWO    = 2'd0,
        ST_DOUBLE = 2'd1,
        ST_NONE   = 2'd2,
        ST_A_ZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic [31:0]        bb;
        logic signed [31:0] ac;
        logic signed [33:0] disc;
        logic [33:0]        rt;
        logic [36:0]        rem;
        logic [34:0]        nm;
        logic [34:0]        np;
        logic [17:0]        rm_r;
        logic [17:0]        rp_r;
        logic               neg_m;
        logic               neg_p;
        logic [16:0]        den;
        status_t            status;
        logic signed [31:0] root_m;
        logic signed [31:0] root_p;
        logic               sat;
    } stage_t;

    function automatic logic signed [31:0] clamp_root(input logic signed [36:0] v,
                                                     inout logic sat);
        logic signed [31:0] r;
        if (v > 37'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
            sat = 1'b1;
        end else if (v < -37'sh0_8000_0000) begin
            r = -32'sh8000_0000;
            sat = 1'b1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic stage_t stage_step(input stage_t p, input int k);
        stage_t             n;
        int                 i;
        int                 sh;
        logic [1:0]         pair;
        logic [36:0]        rem_s;
        logic [36:0]        trial;
        logic               inexact;
        logic signed [16:0] aa;
        logic [16:0]        abs_a;
        logic signed [35:0] cl, sb, base, sub, add, nmv, npv, am, ap;
        logic [17:0]        rs;
        logic [35:0]        mag;
        logic signed [36:0] v;
        n = p;
        if (k == 1) begin
            n.bb = 32'(p.b * p.b);
            n.ac = p.a * p.c;
        end else if (k == 2) begin
            n.disc = $signed({2'b00, p.bb}) - ($signed({{2{p.ac[31]}}, p.ac}) <<< 2);
            n.rt   = '0;
            n.rem  = '0;
        end else if (k >= SQ_FIRST && k < PREP_STAGE) begin
            i  = k - SQ_FIRST;
            sh = (i < SQ_PAIRS) ? 2 * (SQ_PAIRS - 1 - i) : 0;
            pair  = (i < SQ_PAIRS) ? 2'($unsigned(p.disc) >> sh) : 2'b00;
            rem_s = {p.rem[34:0], pair};
            trial = {1'b0, p.rt, 2'b01};
            if (rem_s >= trial) begin
                n.rem = rem_s - trial;
                n.rt  = {p.rt[32:0], 1'b1};
            end else begin
                n.rem = rem_s;
                n.rt  = {p.rt[32:0], 1'b0};
            end
        end else if (k == PREP_STAGE) begin
            inexact = (p.rem != '0);
            aa      = {p.a[15], p.a};
            abs_a   = aa[16] ? 17'(-aa) : 17'(aa);
            cl      = $signed({2'b00, p.rt}) + 36'(inexact);
            sb      = $signed({{4{p.b[15]}}, p.b, 16'h0000});
            base    = ((p.a > 0) ? -sb : sb) + $signed({19'b0, abs_a});
            sub     = base - cl;
            add     = base + $signed({2'b00, p.rt});
            nmv     = (p.a > 0) ? sub : add;
            npv     = (p.a > 0) ? add : sub;
            am      = nmv[35] ? -nmv : nmv;
            ap      = npv[35] ? -npv : npv;
            n.neg_m = nmv[35];
            n.neg_p = npv[35];
            n.nm    = am[34:0];
            n.np    = ap[34:0];
            n.den   = 17'({abs_a, 1'b0});
            n.rm_r  = '0;
            n.rp_r  = '0;
        end else if (k >= DIV_FIRST && k < FIN_STAGE) begin
            rs = {p.rm_r[16:0], p.nm[34]};
            if (rs >= {1'b0, p.den}) begin
                n.rm_r = rs - {1'b0, p.den};
                n.nm   = {p.nm[33:0], 1'b1};
            end else begin
                n.rm_r = rs;
                n.nm   = {p.nm[33:0], 1'b0};
            end
            rs = {p.rp_r[16:0], p.np[34]};
            if (rs >= {1'b0, p.den}) begin
                n.rp_r = rs - {1'b0, p.den};
                n.np   = {p.np[33:0], 1'b1};
            end else begin
                n.rp_r = rs;
                n.np   = {p.np[33:0], 1'b0};
            end
        end else if (k == FIN_STAGE) begin
            n.sat    = 1'b0;
            n.root_m = '0;
            n.root_p = '0;
            if (p.a == 0) begin
                n.status = ST_A_ZERO;
            end else if (p.disc < 0) begin
                n.status = ST_NONE;
            end else begin
                n.status = (p.disc == 0) ? ST_DOUBLE : ST_TWO;
                mag = {1'b0, p.nm} + 36'(p.rm_r != '0 && p.neg_m);
                v   = p.neg_m ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                n.root_m = clamp_root(v, n.sat);
                mag = {1'b0, p.np} + 36'(p.rp_r != '0 && p.neg_p);
                v   = p.neg_p ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                n.root_p = clamp_root(v, n.sat);
            end
        end
        return n;
    endfunction

endpackage

[sv/quadratic_root_solver_unit.sv]
// Quadratic root solver: pipelined discriminant, square root and root division
// Fully pipelined, 73 register stages from input to output, one transaction per
// cycle. Latency is set by the bit-serial square root (33 stages, one result bit
// each) followed by two parallel restoring dividers (35 stages, one quotient bit
// each). The whole pipe advances whenever the output register is empty or taken.
module quadratic_root_solver_unit
    import qrs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [15:0] coef_a, [31:16] coef_b, [47:32] coef_c
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [1:0] status, [33:2] root_minus, [65:34] root_plus,
    // [99:66] discriminant, [100] saturated, [103:101] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    stage_t           pipe_reg  [DEPTH];
    stage_t           pipe_next [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             adv;

    assign adv      = !valid_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;

    always_comb begin
        pipe_next[0]   = '0;
        pipe_next[0].a = s_tdata[15:0];
        pipe_next[0].b = s_tdata[31:16];
        pipe_next[0].c = s_tdata[47:32];
        for (int k = 1; k < DEPTH; k++) begin
            pipe_next[k] = stage_step(pipe_reg[k-1], k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DEPTH; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign m_tvalid = valid_reg[DEPTH-1];
    assign m_tdata  = {3'b000, pipe_reg[DEPTH-1].sat, pipe_reg[DEPTH-1].disc,
                       pipe_reg[DEPTH-1].root_p, pipe_reg[DEPTH-1].root_m,
                       pipe_reg[DEPTH-1].status};

endmodule

[sv/qrs_checker.sv]
// Port-level checker for the quadratic root solver, bound to the top level
`include "quadratic_root_solver_unit_defines.svh"

module qrs_checker
    import qrs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    `QRS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `QRS_ASSERT_SAME(a_zero_roots, m_tvalid && (m_tdata[1:0] == ST_A_ZERO || m_tdata[1:0] == ST_NONE), m_tdata[65:2] == '0 && !m_tdata[100])
    `QRS_ASSERT_SAME(a_none_neg, m_tvalid && m_tdata[1:0] == ST_NONE, m_tdata[99])
    `QRS_ASSERT_SAME(a_double_eq, m_tvalid && m_tdata[1:0] == ST_DOUBLE, m_tdata[33:2] == m_tdata[65:34] && m_tdata[99:66] == '0)

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);
